// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// depends on a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LTCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define LTCW_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/ltcw_pkg.sv -----
// shared types, constants and control store for the lcd text cursor writer
// no dependencies
package ltcw_pkg;

    // display geometry
    localparam int COLUMNS = 32;
    localparam int ROWS    = 16;

    // widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = 16;
    localparam int VAL_W  = 16;
    localparam int NDIG   = 5;
    localparam int DIG_W  = $clog2(NDIG);
    localparam int BITS_W = $clog2(VAL_W + 1);
    localparam int PC_W   = 5;

    // bytes on the display bus
    localparam logic [7:0] SYM_OFFSET      = 8'h20;
    localparam logic [7:0] DIGIT_MARK      = 8'h10;
    localparam logic [7:0] SYM_MINUS       = 8'h0D;
    localparam logic [7:0] CMD_SET_CURSOR  = 8'h21;
    localparam logic [7:0] CMD_SET_ADDR    = 8'h24;
    localparam logic [7:0] CMD_WRITE_INC   = 8'hC0;
    localparam logic [7:0] CMD_READ_INC    = 8'hC1;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_CURSOR  = 2'd2,
        OP_INT     = 2'd3
    } t_op;

    // what a control word puts on the bus
    typedef enum logic [2:0] {
        E_NONE    = 3'd0,
        E_ADDR_LO = 3'd1,
        E_ADDR_HI = 3'd2,
        E_CMD_21  = 3'd3,
        E_CMD_24  = 3'd4,
        E_CMD_C1  = 3'd5,
        E_SYM     = 3'd6,
        E_CMD_C0  = 3'd7
    } t_emit;

    // datapath action of a control word
    typedef enum logic [3:0] {
        A_NONE        = 4'd0,
        A_GOTO_COMMIT = 4'd1,
        A_CNT_DEC     = 4'd2,
        A_TGT_HOME    = 4'd3,
        A_TGT_NEWLINE = 4'd4,
        A_SYM_CHAR    = 4'd5,
        A_SYM_MINUS   = 4'd6,
        A_SYM_DIGIT   = 4'd7,
        A_ADVANCE     = 4'd8,
        A_MAG_LOAD    = 4'd9,
        A_DABBLE      = 4'd10,
        A_DIG_INIT    = 4'd11,
        A_DIG_DEC     = 4'd12
    } t_act;

    // branch condition
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_CNT_ZERO  = 3'd2,
        C_CNT_ONE   = 3'd3,
        C_ROW_OK    = 3'd4,
        C_POS       = 3'd5,
        C_BITS_LEFT = 3'd6,
        C_DIG_LEFT  = 3'd7
    } t_cond;

    // branch kind when the condition holds
    typedef enum logic [2:0] {
        D_JUMP      = 3'd0,
        D_CALL_GOTO = 3'd1,
        D_CALL_SYM  = 3'd2,
        D_RET_GOTO  = 3'd3,
        D_RET_SYM   = 3'd4,
        D_END       = 3'd5
    } t_dest;

    typedef struct packed {
        t_emit             emit;
        t_act              act;
        t_cond             cond;
        t_dest             dest;
        logic [PC_W-1:0]   target;
    } t_uword;

    // control store addresses
    // go-to subroutine
    localparam logic [PC_W-1:0] UA_G_LO     = PC_W'(0);
    localparam logic [PC_W-1:0] UA_G_HI     = PC_W'(1);
    localparam logic [PC_W-1:0] UA_G_21     = PC_W'(2);
    localparam logic [PC_W-1:0] UA_G_24     = PC_W'(3);
    localparam logic [PC_W-1:0] UA_G_C1     = PC_W'(4);
    localparam logic [PC_W-1:0] UA_G_LOOP   = PC_W'(5);
    // print symbol subroutine
    localparam logic [PC_W-1:0] UA_P_CHK    = PC_W'(6);
    localparam logic [PC_W-1:0] UA_P_HOME   = PC_W'(7);
    localparam logic [PC_W-1:0] UA_P_SYM    = PC_W'(8);
    localparam logic [PC_W-1:0] UA_P_C0     = PC_W'(9);
    // command entries
    localparam logic [PC_W-1:0] UA_CHAR     = PC_W'(10);
    localparam logic [PC_W-1:0] UA_CHAR_END = PC_W'(11);
    localparam logic [PC_W-1:0] UA_NL       = PC_W'(12);
    localparam logic [PC_W-1:0] UA_NL_END   = PC_W'(13);
    localparam logic [PC_W-1:0] UA_CUR      = PC_W'(14);
    localparam logic [PC_W-1:0] UA_CUR_END  = PC_W'(15);
    localparam logic [PC_W-1:0] UA_I_LOAD   = PC_W'(16);
    localparam logic [PC_W-1:0] UA_I_MINUS  = PC_W'(17);
    localparam logic [PC_W-1:0] UA_I_DAB    = PC_W'(18);
    localparam logic [PC_W-1:0] UA_I_DINIT  = PC_W'(19);
    localparam logic [PC_W-1:0] UA_I_DIG    = PC_W'(20);
    localparam logic [PC_W-1:0] UA_I_NEXT   = PC_W'(21);
    localparam logic [PC_W-1:0] UA_I_END    = PC_W'(22);

    function automatic t_uword mk(input t_emit e, input t_act a, input t_cond c,
                                  input t_dest d, input logic [PC_W-1:0] t);
        t_uword w;
        w.emit   = e;
        w.act    = a;
        w.cond   = c;
        w.dest   = d;
        w.target = t;
        return w;
    endfunction

    // microprogram: false condition falls through to the next word
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            UA_G_LO:     w = mk(E_ADDR_LO, A_GOTO_COMMIT, C_NEVER, D_JUMP, UA_G_LO);
            UA_G_HI:     w = mk(E_ADDR_HI, A_NONE, C_NEVER, D_JUMP, UA_G_LO);
            UA_G_21:     w = mk(E_CMD_21, A_NONE, C_NEVER, D_JUMP, UA_G_LO);
            UA_G_24:     w = mk(E_CMD_24, A_NONE, C_CNT_ZERO, D_RET_GOTO, UA_G_LO);
            UA_G_C1:     w = mk(E_CMD_C1, A_CNT_DEC, C_CNT_ONE, D_RET_GOTO, UA_G_LO);
            UA_G_LOOP:   w = mk(E_NONE, A_NONE, C_ALWAYS, D_JUMP, UA_G_C1);
            UA_P_CHK:    w = mk(E_NONE, A_NONE, C_ROW_OK, D_JUMP, UA_P_SYM);
            UA_P_HOME:   w = mk(E_NONE, A_TGT_HOME, C_ALWAYS, D_CALL_GOTO, UA_G_LO);
            UA_P_SYM:    w = mk(E_SYM, A_NONE, C_NEVER, D_JUMP, UA_G_LO);
            UA_P_C0:     w = mk(E_CMD_C0, A_ADVANCE, C_ALWAYS, D_RET_SYM, UA_G_LO);
            UA_CHAR:     w = mk(E_NONE, A_SYM_CHAR, C_ALWAYS, D_CALL_SYM, UA_P_CHK);
            UA_CHAR_END: w = mk(E_NONE, A_NONE, C_ALWAYS, D_END, UA_G_LO);
            UA_NL:       w = mk(E_NONE, A_TGT_NEWLINE, C_ALWAYS, D_CALL_GOTO, UA_G_LO);
            UA_NL_END:   w = mk(E_NONE, A_NONE, C_ALWAYS, D_END, UA_G_LO);
            UA_CUR:      w = mk(E_NONE, A_NONE, C_ALWAYS, D_CALL_GOTO, UA_G_LO);
            UA_CUR_END:  w = mk(E_NONE, A_NONE, C_ALWAYS, D_END, UA_G_LO);
            UA_I_LOAD:   w = mk(E_NONE, A_MAG_LOAD, C_POS, D_JUMP, UA_I_DAB);
            UA_I_MINUS:  w = mk(E_NONE, A_SYM_MINUS, C_ALWAYS, D_CALL_SYM, UA_P_CHK);
            UA_I_DAB:    w = mk(E_NONE, A_DABBLE, C_BITS_LEFT, D_JUMP, UA_I_DAB);
            UA_I_DINIT:  w = mk(E_NONE, A_DIG_INIT, C_NEVER, D_JUMP, UA_G_LO);
            UA_I_DIG:    w = mk(E_NONE, A_SYM_DIGIT, C_ALWAYS, D_CALL_SYM, UA_P_CHK);
            UA_I_NEXT:   w = mk(E_NONE, A_DIG_DEC, C_DIG_LEFT, D_JUMP, UA_I_DIG);
            UA_I_END:    w = mk(E_NONE, A_NONE, C_ALWAYS, D_END, UA_G_LO);
            default:     w = mk(E_NONE, A_NONE, C_ALWAYS, D_END, UA_G_LO);
        endcase
        return w;
    endfunction

    // first control word for each command
    function automatic logic [PC_W-1:0] entry_of(input t_op op);
        logic [PC_W-1:0] a;
        case (op)
            OP_CHAR:    a = UA_CHAR;
            OP_NEWLINE: a = UA_NL;
            OP_CURSOR:  a = UA_CUR;
            OP_INT:     a = UA_I_LOAD;
            default:    a = UA_CHAR;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/lcd_text_cursor_writer.sv -----
// Steps one control word per cycle, except while a bus write is held by an output stall;
//   a new command is taken the cycle after the last word. Depends on ltcw_pkg.
//   A printed symbol first homes the cursor when the row is past the last display row.
// Reset is synchronous, active low: sequencer idle, output empty, cursor at column 0, row 0.
module lcd_text_cursor_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_op,
    input  logic signed [15:0]          i_value,
    input  logic [4:0]                  i_col_in,
    input  logic [3:0]                  i_row_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_is_command,
    output logic [7:0]                  o_bus_byte,
    output logic                        o_last
);
    import ltcw_pkg::*;

    // sequencer state
    logic                  r_busy, n_busy;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [PC_W-1:0]       r_ret_goto, n_ret_goto;
    logic [PC_W-1:0]       r_ret_sym, n_ret_sym;
    logic                  r_goto_fin, n_goto_fin;

    // datapath
    logic [VAL_W-1:0]      r_value, n_value;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_tgt_col, n_tgt_col;
    logic [ROW_W-1:0]      r_tgt_row, n_tgt_row;
    logic [COL_W-1:0]      r_cnt, n_cnt;
    logic [7:0]            r_sym, n_sym;
    logic                  r_sym_fin, n_sym_fin;
    logic [VAL_W-1:0]      r_mag, n_mag;
    logic [NDIG-1:0][3:0]  r_bcd, n_bcd;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [DIG_W-1:0]      r_dig, n_dig;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_is_cmd, n_is_cmd;
    logic [7:0]            r_byte, n_byte;
    logic                  r_last, n_last;

    t_uword                uw;
    logic                  slot_free;
    logic                  step;
    logic                  cond_hit;
    logic [ADDR_W-1:0]     addr;
    logic [NDIG-1:0][3:0]  bcd_adj;
    logic                  emit_cmd;
    logic [7:0]            emit_byte;
    logic                  emit_last;

    assign uw        = ucode(r_pc);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign step      = r_busy && ((uw.emit == E_NONE) || slot_free);
    assign addr      = ADDR_W'(r_tgt_row) * ADDR_W'(COLUMNS);

    assign o_in_stall   = r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_is_command = r_is_cmd;
    assign o_bus_byte   = r_byte;
    assign o_last       = r_last;

    // branch condition
    always_comb begin
        case (uw.cond)
            C_NEVER:     cond_hit = 1'b0;
            C_ALWAYS:    cond_hit = 1'b1;
            C_CNT_ZERO:  cond_hit = (r_cnt == '0);
            C_CNT_ONE:   cond_hit = (r_cnt == COL_W'(1));
            C_ROW_OK:    cond_hit = (r_row < ROW_W'(ROWS));
            C_POS:       cond_hit = !r_value[VAL_W-1];
            C_BITS_LEFT: cond_hit = (r_bits != BITS_W'(1));
            C_DIG_LEFT:  cond_hit = (r_dig != '0);
            default:     cond_hit = 1'b0;
        endcase
    end

    // bus write selected by the control word
    always_comb begin
        emit_cmd  = 1'b0;
        emit_byte = 8'h00;
        emit_last = 1'b0;
        case (uw.emit)
            E_ADDR_LO: emit_byte = addr[7:0];
            E_ADDR_HI: emit_byte = addr[15:8];
            E_CMD_21: begin
                emit_cmd  = 1'b1;
                emit_byte = CMD_SET_CURSOR;
            end
            E_CMD_24: begin
                emit_cmd  = 1'b1;
                emit_byte = CMD_SET_ADDR;
                emit_last = r_goto_fin && (r_cnt == '0);
            end
            E_CMD_C1: begin
                emit_cmd  = 1'b1;
                emit_byte = CMD_READ_INC;
                emit_last = r_goto_fin && (r_cnt == COL_W'(1));
            end
            E_SYM:     emit_byte = r_sym;
            E_CMD_C0: begin
                emit_cmd  = 1'b1;
                emit_byte = CMD_WRITE_INC;
                emit_last = r_sym_fin;
            end
            default: begin
                emit_cmd  = 1'b0;
                emit_byte = 8'h00;
                emit_last = 1'b0;
            end
        endcase
    end

    // add-3 adjust ahead of the conversion shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
    end

    // next state
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_ret_goto  = r_ret_goto;
        n_ret_sym   = r_ret_sym;
        n_goto_fin  = r_goto_fin;
        n_value     = r_value;
        n_col       = r_col;
        n_row       = r_row;
        n_tgt_col   = r_tgt_col;
        n_tgt_row   = r_tgt_row;
        n_cnt       = r_cnt;
        n_sym       = r_sym;
        n_sym_fin   = r_sym_fin;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_bits      = r_bits;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && i_out_stall;
        n_is_cmd    = r_is_cmd;
        n_byte      = r_byte;
        n_last      = r_last;

        // input transfer: latch operands and enter the program
        if (!r_busy && i_in_valid) begin
            n_busy     = 1'b1;
            n_pc       = entry_of(t_op'(i_op));
            n_value    = i_value;
            n_goto_fin = (t_op'(i_op) == OP_NEWLINE) || (t_op'(i_op) == OP_CURSOR);
            if (32'(i_col_in) > COLUMNS - 1) begin
                n_tgt_col = COL_W'(COLUMNS - 1);
            end else begin
                n_tgt_col = COL_W'(i_col_in);
            end
            if (32'(i_row_in) > ROWS) begin
                n_tgt_row = ROW_W'(ROWS);
            end else begin
                n_tgt_row = ROW_W'(i_row_in);
            end
        end

        if (step) begin
            // bus write
            if (uw.emit != E_NONE) begin
                n_out_valid = 1'b1;
                n_is_cmd    = emit_cmd;
                n_byte      = emit_byte;
                n_last      = emit_last;
            end

            // datapath action
            case (uw.act)
                A_GOTO_COMMIT: begin
                    n_col = r_tgt_col;
                    n_row = r_tgt_row;
                    n_cnt = r_tgt_col;
                end
                A_CNT_DEC:     n_cnt = r_cnt - COL_W'(1);
                A_TGT_HOME: begin
                    n_tgt_col = '0;
                    n_tgt_row = '0;
                end
                A_TGT_NEWLINE: begin
                    n_tgt_col = '0;
                    n_tgt_row = (r_row < ROW_W'(ROWS)) ? (r_row + ROW_W'(1)) : r_row;
                end
                A_SYM_CHAR: begin
                    n_sym     = r_value[7:0] - SYM_OFFSET;
                    n_sym_fin = 1'b1;
                end
                A_SYM_MINUS: begin
                    n_sym     = SYM_MINUS;
                    n_sym_fin = 1'b0;
                end
                A_SYM_DIGIT: begin
                    n_sym     = {4'h0, r_bcd[r_dig]} | DIGIT_MARK;
                    n_sym_fin = (r_dig == '0);
                end
                A_ADVANCE: begin
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        n_col = '0;
                        if (r_row < ROW_W'(ROWS)) begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
                A_MAG_LOAD: begin
                    n_mag  = r_value[VAL_W-1] ? (~r_value + VAL_W'(1)) : r_value;
                    n_bcd  = '0;
                    n_bits = BITS_W'(VAL_W);
                end
                A_DABBLE: begin
                    n_bcd  = (NDIG*4)'({bcd_adj, r_mag[VAL_W-1]});
                    n_mag  = {r_mag[VAL_W-2:0], 1'b0};
                    n_bits = r_bits - BITS_W'(1);
                end
                A_DIG_INIT: begin
                    n_dig = '0;
                    for (int i = 1; i < NDIG; i++) begin
                        if (r_bcd[i] != 4'h0) begin
                            n_dig = DIG_W'(i);
                        end
                    end
                end
                A_DIG_DEC:     n_dig = r_dig - DIG_W'(1);
                default:       n_cnt = r_cnt;
            endcase

            // sequencing
            if (cond_hit) begin
                case (uw.dest)
                    D_JUMP:      n_pc = uw.target;
                    D_CALL_GOTO: begin
                        n_ret_goto = r_pc + PC_W'(1);
                        n_pc       = uw.target;
                    end
                    D_CALL_SYM: begin
                        n_ret_sym = r_pc + PC_W'(1);
                        n_pc      = uw.target;
                    end
                    D_RET_GOTO:  n_pc = r_ret_goto;
                    D_RET_SYM:   n_pc = r_ret_sym;
                    D_END:       n_busy = 1'b0;
                    default:     n_busy = 1'b0;
                endcase
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= UA_G_LO;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ret_goto <= n_ret_goto;
        r_ret_sym  <= n_ret_sym;
        r_goto_fin <= n_goto_fin;
        r_value    <= n_value;
        r_tgt_col  <= n_tgt_col;
        r_tgt_row  <= n_tgt_row;
        r_cnt      <= n_cnt;
        r_sym      <= n_sym;
        r_sym_fin  <= n_sym_fin;
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_bits     <= n_bits;
        r_dig      <= n_dig;
        r_is_cmd   <= n_is_cmd;
        r_byte     <= n_byte;
        r_last     <= n_last;
    end

endmodule

// ----- rtl/ltcw_checker.sv -----
// port-level checks for lcd_text_cursor_writer, attached by bind
// depends on assert_macros.svh and ltcw_pkg
`include "assert_macros.svh"

module ltcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_command,
    input logic [7:0]  o_bus_byte,
    input logic        o_last
);
    import ltcw_pkg::*;

    logic       out_held;
    logic [9:0] out_word;
    logic       in_fire;
    logic       closing_cmd;

    // views of the ports used by the checks
    assign out_held    = o_out_valid && i_out_stall;
    assign out_word    = {o_is_command, o_bus_byte, o_last};
    assign in_fire     = i_in_valid && !o_in_stall;
    assign closing_cmd = o_is_command &&
                         (o_bus_byte inside {CMD_WRITE_INC, CMD_READ_INC, CMD_SET_ADDR});

    // a stalled bus write holds its contents
    `LTCW_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(out_word), "stalled write changed")

    // every command transfer leaves the sequencer busy in the next cycle
    `LTCW_ASSERT_NEXT(a_busy_after_in, in_fire, o_in_stall, "command transfer did not start")

    // a write marked last is always a write, read or set-address command byte
    `LTCW_ASSERT(a_last_is_cmd, !(o_out_valid && o_last) || closing_cmd, "last write not closing")

    // a data byte never closes a run
    `LTCW_ASSERT(a_setup_is_cmd, !(o_out_valid && !o_is_command) || !o_last, "data byte marked last")

endmodule

bind lcd_text_cursor_writer ltcw_checker u_ltcw_checker (.*);
